@@ sv/cqt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cqt_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 7;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;

  localparam logic [MODE_W-1:0] MODE_ENQ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIZE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_TRAV = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic                do_enq;      // write word at tail, advance tail
    logic                do_deq;      // read head, advance head, drop one
    logic                do_trav;     // read head, start walk
    logic                do_step;     // read walk pointer, advance walk
    logic                load_imm;    // load result beat without memory data
    logic [STATUS_W-1:0] imm_status;
    logic                load_mem;    // load result beat from read data
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
    logic last_entry;
  } sts_t;

endpackage

`default_nettype wire

@@ sv/cqt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cqt_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [cqt_pkg::MODE_W-1:0] in_mode,
  input  wire cqt_pkg::sts_t              sts,
  output cqt_pkg::cmd_t                   cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_OUT  = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign in_ready = (state_r == S_IDLE) && sts.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd            = '0;
    cmd.imm_status = cqt_pkg::ST_OK;
    state_nxt      = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            cqt_pkg::MODE_ENQ: begin
              cmd.load_imm = 1'b1;
              if (sts.full) begin
                cmd.imm_status = cqt_pkg::ST_OVERFLOW;
              end else begin
                cmd.do_enq = 1'b1;
              end
            end
            cqt_pkg::MODE_DEQ: begin
              if (sts.empty) begin
                cmd.load_imm   = 1'b1;
                cmd.imm_status = cqt_pkg::ST_EMPTY;
              end else begin
                cmd.do_deq = 1'b1;
                state_nxt  = S_OUT;
              end
            end
            cqt_pkg::MODE_SIZE: begin
              cmd.load_imm = 1'b1;
            end
            cqt_pkg::MODE_TRAV: begin
              if (sts.empty) begin
                cmd.load_imm   = 1'b1;
                cmd.imm_status = cqt_pkg::ST_EMPTY;
              end else begin
                cmd.do_trav = 1'b1;
                state_nxt   = S_OUT;
              end
            end
            default: ;
          endcase
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_mem = 1'b1;
          if (sts.last_entry) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.do_step = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_no_step_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_step |-> !sts.last_entry) else $error("walk stepped past last entry");

  a_enq_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_enq |-> !sts.full) else $error("write into full queue");

  a_read_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_deq || cmd.do_trav) |=> (state_r == S_OUT)) else $error("read without output");

  a_mem_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_mem |-> (sts.out_free && !in_ready)) else $error("memory beat on busy output");

endmodule

`default_nettype wire

@@ sv/cqt_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cqt_dp #(
  parameter int DEPTH = cqt_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire cqt_pkg::cmd_t                       cmd,
  output cqt_pkg::sts_t                            sts,
  input  wire logic signed [cqt_pkg::DATA_W-1:0]   in_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [cqt_pkg::STATUS_W-1:0]             out_status,
  output logic signed [cqt_pkg::DATA_W-1:0]        out_data,
  output logic [cqt_pkg::COUNT_W-1:0]              out_count,
  output logic                                     out_last
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [cqt_pkg::DATA_W-1:0] mem [DEPTH];
  logic [cqt_pkg::DATA_W-1:0] rd_data_r;
  logic [PTR_W-1:0]           rd_addr;
  logic                       rd_en;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [PTR_W-1:0] walk_r, walk_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;

  logic                               out_valid_r;
  logic [cqt_pkg::STATUS_W-1:0]       out_status_r;
  logic signed [cqt_pkg::DATA_W-1:0]  out_data_r;
  logic [cqt_pkg::COUNT_W-1:0]        out_count_r;
  logic                               out_last_r;

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
    adv = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign sts.full       = (occ_r == CNT_W'(DEPTH));
  assign sts.empty      = (occ_r == '0);
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.last_entry = (remain_r == CNT_W'(1));

  assign rd_en   = cmd.do_deq || cmd.do_trav || cmd.do_step;
  assign rd_addr = cmd.do_step ? walk_r : head_r;

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    walk_nxt   = walk_r;
    occ_nxt    = occ_r;
    remain_nxt = remain_r;
    if (cmd.do_enq) begin
      tail_nxt = adv(tail_r);
      occ_nxt  = occ_r + 1'b1;
    end
    if (cmd.do_deq) begin
      head_nxt   = adv(head_r);
      occ_nxt    = occ_r - 1'b1;
      remain_nxt = CNT_W'(1);
    end
    if (cmd.do_trav) begin
      walk_nxt   = adv(head_r);
      remain_nxt = occ_r;
    end
    if (cmd.do_step) begin
      walk_nxt   = adv(walk_r);
      remain_nxt = remain_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_enq) begin
      mem[tail_r] <= in_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      walk_r      <= '0;
      occ_r       <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      walk_r   <= walk_nxt;
      occ_r    <= occ_nxt;
      remain_r <= remain_nxt;
      if (cmd.load_imm || cmd.load_mem) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload; count on a direct beat is the occupancy after the op
  always_ff @(posedge clk) begin
    if (cmd.load_imm) begin
      out_status_r <= cmd.imm_status;
      out_data_r   <= '0;
      out_count_r  <= cqt_pkg::COUNT_W'(occ_nxt);
      out_last_r   <= 1'b1;
    end else if (cmd.load_mem) begin
      out_status_r <= cqt_pkg::ST_OK;
      out_data_r   <= rd_data_r;
      out_count_r  <= cqt_pkg::COUNT_W'(occ_r);
      out_last_r   <= sts.last_entry;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(DEPTH)) else $error("occupancy beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0 || occ_r == CNT_W'(DEPTH)) |-> (head_r == tail_r))
    else $error("pointers disagree with occupancy");

  a_beat_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> out_valid_r) else $error("result beat dropped");

endmodule

`default_nettype wire

@@ sv/circular_queue_with_traverse_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Enqueue, size, empty dequeue and empty traverse load the result beat straight into the output
// register; a dequeue or a traverse beat passes the registered storage read, then the output register.
// One item per cycle except reads: a dequeue or a traverse holds the input until its last beat is
// loaded, a traverse giving one beat per cycle; output stalls hold back both input and beats.
// Reset (rst_n low, synchronous): queue empty, both pointers at slot 0, no result pending;
// storage contents are not cleared and are never read before being written.

module circular_queue_with_traverse_unit #(
  parameter int DEPTH = cqt_pkg::DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input channel: one beat per requested operation
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [cqt_pkg::MODE_W-1:0]          in_mode,
  input  wire logic signed [cqt_pkg::DATA_W-1:0]   in_value,
  // result channel: one beat per result, last marks the final one of an item
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [cqt_pkg::STATUS_W-1:0]             out_status,
  output logic signed [cqt_pkg::DATA_W-1:0]        out_data,
  output logic [cqt_pkg::COUNT_W-1:0]              out_count,
  output logic                                     out_last
);

  // The controller decodes the operation and sequences multi-beat work;
  // the datapath owns storage, pointers, occupancy and the output register.
  cqt_pkg::cmd_t cmd;
  cqt_pkg::sts_t sts;

  cqt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_mode  (in_mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage read data is registered, so a walk keeps one read in flight and
  // advances the walk pointer each time a beat leaves for the output.
  cqt_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_data   (out_data),
    .out_count  (out_count),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int QDEPTH = cqt_pkg::DEPTH_DEF;
  localparam int HOLD_CYCLES = 300;

  // DUT-facing signals; the ones the bench drives start at known values from time zero
  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [cqt_pkg::MODE_W-1:0]          in_mode = cqt_pkg::MODE_SIZE;
  logic signed [cqt_pkg::DATA_W-1:0]   in_value = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [cqt_pkg::STATUS_W-1:0]        out_status;
  logic signed [cqt_pkg::DATA_W-1:0]   out_data;
  logic [cqt_pkg::COUNT_W-1:0]         out_count;
  logic                                out_last;

  // one result beat as the block should produce it
  typedef struct packed {
    logic [cqt_pkg::STATUS_W-1:0]      status;
    logic signed [cqt_pkg::DATA_W-1:0] data;
    logic [cqt_pkg::COUNT_W-1:0]       count;
    logic                              last;
  } beat_t;

  // Shadow copy of the queue: predicts the beats of every accepted operation
  // and checks each delivered beat against the oldest prediction.
  class queue_shadow;
    logic signed [cqt_pkg::DATA_W-1:0] words [QDEPTH];
    int unsigned head_slot;
    int unsigned tail_slot;
    int unsigned fill;
    beat_t       expected_beats [$];
    int          mismatches;

    function new();
      head_slot  = 0;
      tail_slot  = 0;
      fill       = 0;
      mismatches = 0;
    endfunction

    function int unsigned next_slot(int unsigned p);
      return (p + 1 >= QDEPTH) ? 0 : p + 1;
    endfunction

    function int unsigned stored();
      return fill;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // predict the beats that one accepted operation causes
    function void note_op(logic [cqt_pkg::MODE_W-1:0] mode,
                          logic signed [cqt_pkg::DATA_W-1:0] value);
      beat_t       b;
      int unsigned p;
      b.status = cqt_pkg::ST_OK;
      b.data   = '0;
      b.count  = fill[cqt_pkg::COUNT_W-1:0];
      b.last   = 1'b1;
      case (mode)
        cqt_pkg::MODE_ENQ: begin
          if (fill >= QDEPTH) begin
            b.status = cqt_pkg::ST_OVERFLOW;
          end else begin
            words[tail_slot] = value;
            tail_slot = next_slot(tail_slot);
            fill++;
            b.count = fill[cqt_pkg::COUNT_W-1:0];
          end
          expected_beats.push_back(b);
        end
        cqt_pkg::MODE_DEQ: begin
          if (fill == 0) begin
            b.status = cqt_pkg::ST_EMPTY;
          end else begin
            b.data = words[head_slot];
            head_slot = next_slot(head_slot);
            fill--;
            b.count = fill[cqt_pkg::COUNT_W-1:0];
          end
          expected_beats.push_back(b);
        end
        cqt_pkg::MODE_SIZE: begin
          expected_beats.push_back(b);
        end
        default: begin
          // traverse: one beat per stored word, oldest first
          if (fill == 0) begin
            b.status = cqt_pkg::ST_EMPTY;
            expected_beats.push_back(b);
          end else begin
            p = head_slot;
            for (int k = 0; k < fill; k++) begin
              b.data = words[p];
              b.last = (k + 1 == fill);
              expected_beats.push_back(b);
              p = next_slot(p);
            end
          end
        end
      endcase
    endfunction

    // compare a delivered beat with the oldest prediction
    function void check_beat(beat_t got);
      beat_t want;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: status=%0d data=%0d count=%0d last=%0d",
                   got.status, got.data, got.count, got.last);
        return;
      end
      want = expected_beats.pop_front();
      if (got.status !== want.status || got.data !== want.data ||
          got.count !== want.count || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat mismatch: expected status=%0d data=%0d count=%0d last=%0d, %s%0d %s%0d %s%0d %s%0d",
                   want.status, want.data, want.count, want.last,
                   "got status=", got.status, "data=", got.data,
                   "count=", got.count, "last=", got.last);
      end
    endfunction
  endclass

  queue_shadow sb;
  int          n_sent = 0;
  bit          tx_calm = 1'b0;      // no input gaps while set
  bit          rx_hold_req = 1'b0;  // ask the receiver for one long hold-off
  int          rx_cnt = 0;

  circular_queue_with_traverse_unit #(
    .DEPTH(QDEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_value  (in_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_status(out_status),
    .out_data  (out_data),
    .out_count (out_count),
    .out_last  (out_last)
  );

  always #4 clk = ~clk;

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Check every beat that moves on the result channel.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_beat('{out_status, out_data, out_count, out_last});
  end

  // Pace the receiver: mostly ready, short stalls, a few long ones, calm runs,
  // and one long hold-off on request so the block backs up into its input.
  always @(posedge clk) begin : rx_pace
    int r;
    if (rx_cnt > 0) begin
      rx_cnt = rx_cnt - 1;
    end else if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      out_ready <= 1'b0;
      rx_cnt = HOLD_CYCLES;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_ready <= 1'b1;
        rx_cnt = (r < 8) ? $urandom_range(40, 120) : $urandom_range(0, 6);
      end else begin
        out_ready <= 1'b0;
        rx_cnt = (r >= 95) ? $urandom_range(10, 30) : $urandom_range(0, 2);
      end
    end
  end

  function automatic int gap_len();
    int r;
    if (tx_calm)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // favor the word extremes now and then
  function automatic logic signed [cqt_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [cqt_pkg::MODE_W-1:0] pick_mode(int ew, int dw, int sw, int tw);
    int r;
    r = $urandom_range(0, ew + dw + sw + tw - 1);
    if (r < ew)
      return cqt_pkg::MODE_ENQ;
    if (r < ew + dw)
      return cqt_pkg::MODE_DEQ;
    if (r < ew + dw + sw)
      return cqt_pkg::MODE_SIZE;
    return cqt_pkg::MODE_TRAV;
  endfunction

  // Offer one beat, hold it until accepted, then idle for a random gap.
  task automatic send_item(input logic [cqt_pkg::MODE_W-1:0] mode,
                           input logic signed [cqt_pkg::DATA_W-1:0] value);
    int n;
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_op(mode, value);
    n_sent++;
    n = gap_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop valid and hold until every predicted beat has arrived.
  task automatic wait_results();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Enqueue until full, push into overflow, then walk the full queue.
  task automatic fill_up();
    while (sb.stored() < QDEPTH) send_item(cqt_pkg::MODE_ENQ, pick_value());
    repeat (2) send_item(cqt_pkg::MODE_ENQ, pick_value());
    send_item(cqt_pkg::MODE_TRAV, pick_value());
    send_item(cqt_pkg::MODE_SIZE, pick_value());
  endtask

  // Dequeue until empty, then underflow and walk the empty queue.
  task automatic drain_out();
    while (sb.stored() > 0) send_item(cqt_pkg::MODE_DEQ, pick_value());
    repeat (2) send_item(cqt_pkg::MODE_DEQ, pick_value());
    send_item(cqt_pkg::MODE_TRAV, pick_value());
  endtask

  initial begin : stimulus
    int kind;
    int seg;
    int ew, dw, sw, tw;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty-queue cases first
    send_item(cqt_pkg::MODE_SIZE, 32'h0);
    send_item(cqt_pkg::MODE_DEQ, 32'hffff_ffff);
    send_item(cqt_pkg::MODE_TRAV, 32'h8000_0000);
    // word extremes and alternating patterns
    send_item(cqt_pkg::MODE_ENQ, 32'h7fff_ffff);
    send_item(cqt_pkg::MODE_ENQ, 32'h8000_0000);
    send_item(cqt_pkg::MODE_ENQ, 32'h0000_0000);
    send_item(cqt_pkg::MODE_ENQ, 32'hffff_ffff);
    send_item(cqt_pkg::MODE_ENQ, 32'h5555_5555);
    send_item(cqt_pkg::MODE_ENQ, 32'haaaa_aaaa);
    send_item(cqt_pkg::MODE_SIZE, 32'h7fff_ffff);
    send_item(cqt_pkg::MODE_TRAV, 32'h0);
    repeat (6) send_item(cqt_pkg::MODE_DEQ, 32'h0);
    send_item(cqt_pkg::MODE_DEQ, 32'h0);
    send_item(cqt_pkg::MODE_TRAV, 32'h0);
    send_item(cqt_pkg::MODE_SIZE, 32'h0);
    // sender pause: let the result side catch up completely
    wait_results();

    // full queue, overflow, wrap of the tail pointer
    fill_up();
    repeat (10) send_item(pick_mode(70, 10, 10, 10), pick_value());

    // long receiver hold-off while the sender keeps pushing
    rx_hold_req = 1'b1;
    tx_calm = 1'b1;
    repeat (60) send_item(pick_mode(45, 20, 25, 10), pick_value());
    tx_calm = 1'b0;

    drain_out();
    wait_results();

    // random segments with shifting operation mix
    while (n_sent < 400) begin
      kind = $urandom_range(0, 6);
      seg  = $urandom_range(25, 45);
      tx_calm = (kind == 3);
      case (kind)
        0: begin ew = 60; dw = 20; sw = 8;  tw = 12; end
        1: begin ew = 20; dw = 60; sw = 10; tw = 10; end
        2, 3: begin ew = 40; dw = 35; sw = 13; tw = 12; end
        default: begin ew = 45; dw = 45; sw = 5; tw = 5; end
      endcase
      if (kind == 4) begin
        fill_up();
      end else if (kind == 5) begin
        drain_out();
      end else begin
        repeat (seg) send_item(pick_mode(ew, dw, sw, tw), pick_value());
      end
      tx_calm = 1'b0;
    end

    wait_results();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
